// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl of the blend block
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== rtl/cac_pkg.sv =====
// shared types and constants for the coverage alpha composite block
// no dependencies; imported by the top level and its testbench
package cac_pkg;

   localparam logic [7:0] FullScale = 8'd255;

   typedef struct packed {
      logic [7:0] src_red;
      logic [7:0] src_green;
      logic [7:0] src_blue;
      logic [7:0] src_alpha;
      logic [7:0] coverage;
      logic [7:0] dst_red;
      logic [7:0] dst_green;
      logic [7:0] dst_blue;
      logic [7:0] dst_alpha;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       blended;
   } rsp_word_type;

endpackage

// ===== rtl/coverage_alpha_composite.sv =====
// coverage alpha composite: straight-alpha source-over blend, eight-stage pipeline
// depends on cac_pkg and assert_macros.svh
//
//   channel   direction   handshake              word
//   req       in          req_valid / req_stall  req_word_type (source, coverage, dest)
//   rsp       out         rsp_valid / rsp_stall  rsp_word_type (blended pixel, flag)
//
// one word accepted per cycle sustained while rsp does not stall; a result passes through
// the eight register stages (coverage product, scaled alpha and weight
// product, weight split, channel products, numerators, then three stages of restoring
// division by the blended alpha, three quotient bits each)
// reset is synchronous and clears only the stage valid bits
// stalls: each stage takes a new word when it is empty or its successor moves, so
// bubbles collapse; req_stall is high only while all stages are full and rsp stalls
`include "assert_macros.svh"

module coverage_alpha_composite
   import cac_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int NumStages = 8;
   localparam int StE       = 4;

   typedef logic [7:0]         pix_type;
   typedef logic [15:0]        prod_type;
   typedef pix_type  [2:0]     rgb_type;
   typedef prod_type [2:0]     prod3_type;

   // stage a: coverage product
   typedef struct packed {
      rgb_type  s;
      rgb_type  d;
      pix_type  da;
      prod_type p;
   } st_a_type;

   // stage b: scaled alpha and dest weight product
   typedef struct packed {
      rgb_type  s;
      rgb_type  d;
      pix_type  da;
      pix_type  sa;
      prod_type t;
   } st_b_type;

   // stage c: dest weight split as 255*a + b, blended alpha
   typedef struct packed {
      rgb_type s;
      rgb_type d;
      pix_type da;
      pix_type sa;
      pix_type a;
      pix_type b;
      pix_type oa;
   } st_c_type;

   // stage d: per channel partial products
   typedef struct packed {
      rgb_type   d;
      pix_type   da;
      logic      pass;
      pix_type   oa;
      prod3_type ps;
      prod3_type pa;
      prod3_type pb;
   } st_d_type;

   // stage e: per channel numerators
   typedef struct packed {
      rgb_type   d;
      pix_type   da;
      logic      pass;
      pix_type   oa;
      prod3_type num;
   } st_e_type;

   // stage f: first three quotient bits
   typedef struct packed {
      rgb_type               d;
      pix_type               da;
      logic                  pass;
      pix_type               oa;
      rgb_type               rem;
      logic [2:0][2:0]       q;
      logic [2:0][5:0]       low;
   } st_f_type;

   // stage g: six quotient bits
   typedef struct packed {
      rgb_type               d;
      pix_type               da;
      logic                  pass;
      pix_type               oa;
      rgb_type               rem;
      logic [2:0][5:0]       q;
      logic [2:0][2:0]       low;
   } st_g_type;

   // x / 255 for x up to 255*255
   function automatic pix_type div255(input prod_type x);
      logic [16:0] sum;
      sum = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

   // three restoring division steps; rem stays below den
   function automatic logic [10:0] div_step3(input pix_type rem, input logic [2:0] bits,
                                             input pix_type den);
      logic [8:0] r;
      logic [7:0] rr;
      logic [2:0] q;
      rr = rem;
      q  = '0;
      for (int i = 2; i >= 0; i--) begin
         r = {rr, bits[i]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[i] = 1'b1;
         end
         rr = r[7:0];
      end
      return {rr, q};
   endfunction

   // pipeline control
   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] vld_in;
   logic [NumStages-1:0] rdy;

   st_a_type     a_ff, a_in;
   st_b_type     b_ff, b_in;
   st_c_type     c_ff, c_in;
   st_d_type     d_ff, d_in;
   st_e_type     e_ff, e_in;
   st_f_type     f_ff, f_in;
   st_g_type     g_ff, g_in;
   rsp_word_type h_ff, h_in;

   // a stage moves when empty or when the next one moves
   always_comb begin
      rdy[NumStages-1] = !vld_ff[NumStages-1] || !rsp_stall;
      for (int i = NumStages - 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in[0] = rdy[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < NumStages; i++) begin
         vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[NumStages-1];
   assign rsp_word  = h_ff;

   // stage a: src_alpha * coverage
   always_comb begin
      a_in.s  = {req_word.src_red, req_word.src_green, req_word.src_blue};
      a_in.d  = {req_word.dst_red, req_word.dst_green, req_word.dst_blue};
      a_in.da = req_word.dst_alpha;
      a_in.p  = {8'h00, req_word.src_alpha} * {8'h00, req_word.coverage};
   end

   // stage b: scaled alpha, then dst_alpha * (255 - sa)
   always_comb begin
      pix_type inv;
      b_in.s  = a_ff.s;
      b_in.d  = a_ff.d;
      b_in.da = a_ff.da;
      b_in.sa = div255(a_ff.p);
      inv     = FullScale - b_in.sa;
      b_in.t  = {8'h00, a_ff.da} * {8'h00, inv};
   end

   // stage c: t = 255*a + b, so d*t/255 = d*a + d*b/255 exactly
   always_comb begin
      prod_type rem16;
      logic [8:0] oa9;
      c_in.s  = b_ff.s;
      c_in.d  = b_ff.d;
      c_in.da = b_ff.da;
      c_in.sa = b_ff.sa;
      c_in.a  = div255(b_ff.t);
      rem16   = b_ff.t - {c_in.a, 8'h00} + {8'h00, c_in.a};
      c_in.b  = rem16[7:0];
      // sa + da*(255-sa)/255 never exceeds 255
      oa9     = {1'b0, b_ff.sa} + {1'b0, c_in.a};
      c_in.oa = oa9[7:0];
   end

   // stage d: products for each color channel
   always_comb begin
      d_in.d    = c_ff.d;
      d_in.da   = c_ff.da;
      d_in.pass = (c_ff.sa == 8'h00);
      d_in.oa   = c_ff.oa;
      for (int c = 0; c < 3; c++) begin
         d_in.ps[c] = {8'h00, c_ff.s[c]} * {8'h00, c_ff.sa};
         d_in.pa[c] = {8'h00, c_ff.d[c]} * {8'h00, c_ff.a};
         d_in.pb[c] = {8'h00, c_ff.d[c]} * {8'h00, c_ff.b};
      end
   end

   // stage e: numerators, bounded by 255*oa + 254
   always_comb begin
      logic [16:0] num17;
      e_in.d    = d_ff.d;
      e_in.da   = d_ff.da;
      e_in.pass = d_ff.pass;
      e_in.oa   = d_ff.oa;
      for (int c = 0; c < 3; c++) begin
         num17 = {1'b0, d_ff.ps[c]} + {1'b0, d_ff.pa[c]} + {9'b0, div255(d_ff.pb[c])};
         e_in.num[c] = num17[15:0];
      end
   end

   // stage f: quotient bits 8..6; num >> 9 is below oa
   always_comb begin
      logic [10:0] step;
      f_in.d    = e_ff.d;
      f_in.da   = e_ff.da;
      f_in.pass = e_ff.pass;
      f_in.oa   = e_ff.oa;
      for (int c = 0; c < 3; c++) begin
         step        = div_step3({1'b0, e_ff.num[c][15:9]}, e_ff.num[c][8:6], e_ff.oa);
         f_in.rem[c] = step[10:3];
         f_in.q[c]   = step[2:0];
         f_in.low[c] = e_ff.num[c][5:0];
      end
   end

   // stage g: quotient bits 5..3
   always_comb begin
      logic [10:0] step;
      g_in.d    = f_ff.d;
      g_in.da   = f_ff.da;
      g_in.pass = f_ff.pass;
      g_in.oa   = f_ff.oa;
      for (int c = 0; c < 3; c++) begin
         step        = div_step3(f_ff.rem[c], f_ff.low[c][5:3], f_ff.oa);
         g_in.rem[c] = step[10:3];
         g_in.q[c]   = {f_ff.q[c], step[2:0]};
         g_in.low[c] = f_ff.low[c][2:0];
      end
   end

   // stage h: last quotient bits, saturation and pass-through select
   always_comb begin
      logic [10:0] step;
      logic [8:0]  q9;
      rgb_type     ch;
      for (int c = 0; c < 3; c++) begin
         step  = div_step3(g_ff.rem[c], g_ff.low[c], g_ff.oa);
         q9    = {g_ff.q[c], step[2:0]};
         ch[c] = q9[8] ? FullScale : q9[7:0];
      end
      if (g_ff.pass) begin
         h_in.out_red   = g_ff.d[2];
         h_in.out_green = g_ff.d[1];
         h_in.out_blue  = g_ff.d[0];
         h_in.out_alpha = g_ff.da;
      end else begin
         h_in.out_red   = ch[2];
         h_in.out_green = ch[1];
         h_in.out_blue  = ch[0];
         h_in.out_alpha = g_ff.oa;
      end
      h_in.blended = !g_ff.pass;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage data, loaded whenever the stage moves
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         a_ff <= a_in;
      end
      if (rdy[1]) begin
         b_ff <= b_in;
      end
      if (rdy[2]) begin
         c_ff <= c_in;
      end
      if (rdy[3]) begin
         d_ff <= d_in;
      end
      if (rdy[4]) begin
         e_ff <= e_in;
      end
      if (rdy[5]) begin
         f_ff <= f_in;
      end
      if (rdy[6]) begin
         g_ff <= g_in;
      end
      if (rdy[7]) begin
         h_ff <= h_in;
      end
   end

   // input side backs up only when every stage holds a word and the output stalls
   `ASSERT_IMPLY(a_stall_full, clock, reset, req_stall, (&vld_ff) && rsp_stall)

   // divider precondition: top numerator bits below the blended alpha
   `ASSERT_IMPLY(a_div_range, clock, reset, vld_ff[StE] && !e_ff.pass,
      ({1'b0, e_ff.num[0][15:9]} < e_ff.oa) && ({1'b0, e_ff.num[1][15:9]} < e_ff.oa) &&
      ({1'b0, e_ff.num[2][15:9]} < e_ff.oa))

   // a blended word always carries nonzero alpha
   `ASSERT_IMPLY(a_blend_alpha, clock, reset, rsp_valid && rsp_word.blended,
      rsp_word.out_alpha != 8'h00)

endmodule

// ===== test/coverage_alpha_composite_tb.sv =====
// testbench for the coverage alpha composite blend block: directed and random pixels
// with random idling on both channels, checked against a scoreboard of predicted words
// depends on cac_pkg and the block's rtl
`timescale 1ns / 100ps

module coverage_alpha_composite_tb
   import cac_pkg::*;
();

   // run ends here no matter what; far above the slowest legal run
   localparam int unsigned CycleLimit = 1_000_000;
   localparam int unsigned RandomPixels = 1900;
   // cycles to linger after the last expected word
   localparam int unsigned DrainCycles = 20;
   localparam int unsigned FullLevel = 32'(FullScale);

   // scoreboard: predicts each result word at accept time, checks results in order
   class blend_scoreboard;
      rsp_word_type expected_pixels[$];
      int unsigned  mismatches;

      function bit [7:0] blend_channel(int unsigned s, int unsigned d, int unsigned sa,
                                       int unsigned da, int unsigned inv, int unsigned oa);
         int unsigned mix;
         int unsigned level;
         mix = s * sa + (d * da * inv) / FullLevel;
         level = mix / oa;
         // saturate rather than wrap
         return (level > FullLevel) ? FullScale : level[7:0];
      endfunction

      function rsp_word_type blend_pixel(req_word_type w);
         rsp_word_type r;
         int unsigned  sa;
         int unsigned  da;
         int unsigned  inv;
         int unsigned  oa;
         sa = (32'(w.src_alpha) * 32'(w.coverage)) / FullLevel;
         da = 32'(w.dst_alpha);
         if (sa == 0) begin
            // nothing to paint: destination passes through
            r.out_red   = w.dst_red;
            r.out_green = w.dst_green;
            r.out_blue  = w.dst_blue;
            r.out_alpha = w.dst_alpha;
            r.blended   = 1'b0;
         end else begin
            inv = FullLevel - sa;
            oa  = sa + (da * inv) / FullLevel;
            r.out_red   = blend_channel(32'(w.src_red), 32'(w.dst_red), sa, da, inv, oa);
            r.out_green = blend_channel(32'(w.src_green), 32'(w.dst_green), sa, da, inv, oa);
            r.out_blue  = blend_channel(32'(w.src_blue), 32'(w.dst_blue), sa, da, inv, oa);
            r.out_alpha = oa[7:0];
            r.blended   = 1'b1;
         end
         return r;
      endfunction

      function void note_pixel(req_word_type w);
         expected_pixels = {expected_pixels, blend_pixel(w)};
      endfunction

      function void check_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         end
      endfunction

      function void check_pixel(rsp_word_type got);
         rsp_word_type want;
         if (expected_pixels.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected word, expected none, got %h", $time, got);
         end else begin
            want = expected_pixels[0];
            expected_pixels.delete(0);
            check_field("out_red", 32'(want.out_red), 32'(got.out_red));
            check_field("out_green", 32'(want.out_green), 32'(got.out_green));
            check_field("out_blue", 32'(want.out_blue), 32'(got.out_blue));
            check_field("out_alpha", 32'(want.out_alpha), 32'(got.out_alpha));
            check_field("blended", 32'(want.blended), 32'(got.blended));
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   blend_scoreboard board = new();
   int unsigned     pixels_accepted;
   int unsigned     cycle_count = 0;

   coverage_alpha_composite i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung block or a lost word ends here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("coverage_alpha_composite verification failed");
         $finish;
      end
   end

   // result monitor: values read at the edge are the ones the block saw
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_pixel(rsp_word);
   end

   // receiver: random stall stretches, free-running stretches, and one long
   // hold-off partway in so the pipeline fills and pushes back on the sender
   initial begin
      int unsigned stall_left;
      int unsigned free_left;
      int unsigned pick;
      bit          choked;
      stall_left = 0;
      free_left  = 0;
      choked     = 1'b0;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!choked && pixels_accepted >= 700) begin
            choked     = 1'b1;
            stall_left = 150;
            free_left  = 0;
         end else if (stall_left == 0 && free_left == 0) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
               free_left = $urandom_range(20, 100);
            end else if (pick < 9) begin
               stall_left = $urandom_range(1, 3);
               free_left  = $urandom_range(0, 5);
            end else begin
               stall_left = $urandom_range(10, 40);
               free_left  = $urandom_range(0, 5);
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (free_left > 0)
               free_left--;
         end
         @(posedge clock);
      end
   end

   // offer one word after an idle gap; valid stays up across back-to-back words
   task automatic send_pixel(input req_word_type w, input int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      board.note_pixel(w);
      pixels_accepted++;
   endtask

   function automatic req_word_type make_pixel(bit [7:0] sr, bit [7:0] sg, bit [7:0] sb,
                                               bit [7:0] sa, bit [7:0] cov, bit [7:0] dr,
                                               bit [7:0] dg, bit [7:0] db, bit [7:0] da);
      req_word_type w;
      w.src_red   = sr;
      w.src_green = sg;
      w.src_blue  = sb;
      w.src_alpha = sa;
      w.coverage  = cov;
      w.dst_red   = dr;
      w.dst_green = dg;
      w.dst_blue  = db;
      w.dst_alpha = da;
      return w;
   endfunction

   // idle gap policy: bursts with no gaps, else mostly none, some short and a few long
   function automatic int unsigned pick_gap(bit burst);
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (burst || pick < 12)
         return 0;
      else if (pick < 18)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic req_word_type random_pixel();
      req_word_type w;
      w = req_word_type'(72'({$urandom, $urandom, $urandom}));
      case ($urandom_range(0, 9))
         0: begin
            // zero scaled alpha by zero coverage or zero source alpha
            if ($urandom_range(0, 1)) w.coverage = 8'd0;
            else w.src_alpha = 8'd0;
         end
         1: begin
            // scaled alpha right at the truncation edge of zero and one
            w.src_alpha = 8'($urandom_range(250, 255));
            w.coverage  = 8'($urandom_range(0, 2));
         end
         2: begin
            // opaque source with full coverage replaces the destination
            w.src_alpha = FullScale;
            w.coverage  = FullScale;
         end
         3: begin
            // faint source over nearly clear destination: saturation hunting
            w.src_alpha = FullScale;
            w.coverage  = 8'($urandom_range(1, 4));
            w.dst_alpha = 8'($urandom_range(0, 3));
            w.src_red   = 8'($urandom_range(240, 255));
            w.dst_red   = 8'($urandom_range(240, 255));
         end
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      req_word_type directed[$];
      bit           burst;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      pixels_accepted = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes and the special cases
      directed = {directed, make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0)};
      directed = {directed, make_pixel(255, 255, 255, 255, 255, 255, 255, 255, 255)};
      // pass-through: zero coverage, zero source alpha, product truncating to zero
      directed = {directed, make_pixel(200, 100, 50, 255, 0, 11, 22, 33, 44)};
      directed = {directed, make_pixel(200, 100, 50, 0, 255, 55, 66, 77, 88)};
      directed = {directed, make_pixel(255, 255, 255, 254, 1, 1, 2, 3, 4)};
      // smallest nonzero scaled alpha over a nearly clear destination saturates
      directed = {directed, make_pixel(255, 255, 255, 255, 1, 255, 255, 255, 1)};
      directed = {directed, make_pixel(255, 0, 254, 255, 1, 255, 255, 250, 1)};
      directed = {directed, make_pixel(255, 255, 255, 255, 1, 255, 255, 255, 0)};
      // opaque source replaces, clear and opaque destinations
      directed = {directed, make_pixel(12, 34, 56, 255, 255, 200, 201, 202, 203)};
      directed = {directed, make_pixel(90, 180, 30, 128, 200, 255, 0, 128, 0)};
      directed = {directed, make_pixel(90, 180, 30, 128, 200, 255, 0, 128, 255)};
      directed = {directed, make_pixel(0, 0, 0, 128, 128, 255, 255, 255, 255)};
      directed = {directed, make_pixel(255, 255, 255, 1, 255, 0, 0, 0, 255)};
      // alternating bit patterns
      directed = {directed, make_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
                                       8'h55, 8'hAA)};
      directed = {directed, make_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
                                       8'hAA, 8'h55)};
      foreach (directed[i])
         send_pixel(directed[i], pick_gap(1'b0));

      // random pixels; gap-free bursts alternate with idling stretches
      burst = 1'b0;
      for (int unsigned n = 0; n < RandomPixels; n++) begin
         if (n % 150 == 0)
            burst = ($urandom_range(0, 2) == 0);
         send_pixel(random_pixel(), pick_gap(burst));
      end
      req_valid <= 1'b0;

      // drain, then linger to catch stray words
      while (board.expected_pixels.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (board.mismatches == 0)
         $display("coverage_alpha_composite verification clean");
      else
         $display("coverage_alpha_composite verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/cac_pkg.sv
rtl/coverage_alpha_composite.sv
test/coverage_alpha_composite_tb.sv
